>>> design/cctu_pkg.sv
// Shared types, codes and sizing constants for the capture/compare timer unit.
`default_nettype none

package cctu_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int TIMER_BITS   = 16;
    localparam int NUM_TIMERS   = 2;
    localparam int MAX_CHANNELS = 16;
    localparam int NIBBLE_CHANNELS = 8;
    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;
    localparam int REQ_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_PIN      = 2'd1,
        FUNC_WR_CHAN  = 2'd2,
        FUNC_WR_TIMER = 2'd3
    } cctu_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_CONTROL = 2'd0,
        CFG_RELOAD_ZERO   = 2'd1,
        CFG_RELOAD_ONE    = 2'd2,
        CFG_CHANNEL_MODES = 2'd3
    } cctu_cfg_idx_t;

    // Capture modes in bits 2:0 of a channel nibble; any code with bit 2 set is compare.
    localparam logic [2:0] MODE_RISE = 3'd1;
    localparam logic [2:0] MODE_FALL = 3'd2;
    localparam logic [2:0] MODE_BOTH = 3'd3;
    localparam int MODE_CMP_BIT = 2;
    localparam int MODE_SEL_BIT = 3;

    typedef struct packed {
        cctu_func_t        func;
        logic [IDX_W-1:0]  idx;
        logic              level;
        logic [DATA_W-1:0] data;
        logic              ovf_in;
    } cctu_item_t;

    typedef struct packed {
        logic                  tick;
        logic                  wr;
        logic [TIMER_BITS-1:0] wr_data;
        logic                  wr_ovf;
        logic [TIMER_BITS-1:0] reload;
    } cctu_timer_ctl_t;

    typedef struct packed {
        logic [TIMER_BITS-1:0] count_next;
        logic                  ovf_next;
        logic                  wrapped;
        logic                  incr;
    } cctu_timer_sts_t;

endpackage

`default_nettype wire

>>> design/cctu_timer.sv
// One up-counting timer with reload, sticky overflow flag and direct write.
`default_nettype none

module cctu_timer
    import cctu_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire cctu_timer_ctl_t ctl,
    output logic [TIMER_BITS-1:0] count_cur,
    output cctu_timer_sts_t      sts
);

    logic [TIMER_BITS-1:0] count_reg;
    logic                  ovf_reg;

    always_comb begin
        sts.wrapped = ctl.tick && (count_reg == '1);
        sts.incr    = ctl.tick && !sts.wrapped;
        priority if (ctl.wr) begin
            sts.count_next = ctl.wr_data;
            sts.ovf_next   = ctl.wr_ovf;
        end else if (sts.wrapped) begin
            sts.count_next = ctl.reload;
            sts.ovf_next   = 1'b1;
        end else if (sts.incr) begin
            sts.count_next = count_reg + TIMER_BITS'(1);
            sts.ovf_next   = ovf_reg;
        end else begin
            sts.count_next = count_reg;
            sts.ovf_next   = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (step_en) begin
            count_reg <= sts.count_next;
            ovf_reg   <= sts.ovf_next;
        end
    end

    assign count_cur = count_reg;

endmodule

`default_nettype wire

>>> design/cctu_channels.sv
// Capture/compare channel bank: channel values, compare hits, captures and writes.
`default_nettype none

module cctu_channels
    import cctu_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step_en,
    input  wire cctu_item_t            item,
    input  wire logic [CFG_DATA_W-1:0] modes,
    input  wire logic [TIMER_BITS-1:0] count_cur [NUM_TIMERS],
    input  wire cctu_timer_sts_t       tmr_sts [NUM_TIMERS],
    output logic [REQ_W-1:0]           requests,
    output logic [DATA_W-1:0]          value_out
);

    logic [DATA_W-1:0]       chan_reg  [NUM_CHANNELS];
    logic [DATA_W-1:0]       chan_next [NUM_CHANNELS];
    logic [3:0]              nib       [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] req_vec;

    // Channels past the last nibble of the mode register behave as off.
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_nib
        if (g < NIBBLE_CHANNELS) begin : g_have
            assign nib[g] = modes[4*g +: 4];
        end else begin : g_none
            assign nib[g] = 4'd0;
        end
    end

    always_comb begin
        logic             sel;
        logic             fire;
        logic [2:0]       mode;
        for (int m = 0; m < NUM_CHANNELS; m++) begin
            sel  = nib[m][MODE_SEL_BIT];
            mode = nib[m][2:0];
            fire = 1'b0;
            chan_next[m] = chan_reg[m];
            req_vec[m]   = 1'b0;
            if (tmr_sts[sel].incr && mode[MODE_CMP_BIT] &&
                CMP_W'(chan_reg[m]) == CMP_W'(tmr_sts[sel].count_next)) begin
                req_vec[m] = 1'b1;
            end
            if (int'(item.idx) == m) begin
                fire = (mode == MODE_RISE && item.level) ||
                       (mode == MODE_FALL && !item.level) ||
                       (mode == MODE_BOTH);
                if (item.func == FUNC_PIN && fire) begin
                    chan_next[m] = DATA_W'(count_cur[sel]);
                    req_vec[m]   = 1'b1;
                end else if (item.func == FUNC_WR_CHAN) begin
                    chan_next[m] = item.data;
                end
            end
        end
    end

    always_comb begin
        logic [MAX_CHANNELS-1:0] req_ext;
        req_ext   = MAX_CHANNELS'(req_vec);
        requests  = req_ext[REQ_W-1:0];
        value_out = '0;
        for (int m = 0; m < NUM_CHANNELS; m++) begin
            if (int'(item.idx) == m) begin
                value_out = chan_next[m];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < NUM_CHANNELS; m++) begin
                chan_reg[m] <= '0;
            end
        end else if (step_en) begin
            for (int m = 0; m < NUM_CHANNELS; m++) begin
                chan_reg[m] <= chan_next[m];
            end
        end
    end

endmodule

`default_nettype wire

>>> design/capture_compare_timer_unit_core.sv
// Path: an input transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle unless the result is stalled; the timer and channel
// state update in the same cycle an item moves from the input register into the result register.
// Reset: synchronous, active low; clears timers, flags, channel values, configuration registers and valids.
// Configuration writes are always ready and take effect on the next clock.
// Top level of the capture/compare timer unit.
`default_nettype none

module capture_compare_timer_unit_core
    import cctu_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [FUNC_W-1:0]     s_func,
    input  wire logic [IDX_W-1:0]      s_index,
    input  wire logic                  s_level,
    input  wire logic [DATA_W-1:0]     s_data,
    input  wire logic                  s_overflow_in,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [REQ_W-1:0]           m_channel_requests,
    output logic [NUM_TIMERS-1:0]      m_wrap_requests,
    output logic [DATA_W-1:0]          m_timer_zero_value,
    output logic [DATA_W-1:0]          m_timer_one_value,
    output logic [NUM_TIMERS-1:0]      m_overflow_flags,
    output logic [DATA_W-1:0]          m_channel_value,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [3:0]            timer_control_reg;
    logic [DATA_W-1:0]     reload_zero_reg;
    logic [DATA_W-1:0]     reload_one_reg;
    logic [CFG_DATA_W-1:0] channel_modes_reg;

    logic       in_valid_reg;
    cctu_item_t in_item_reg;
    logic       step_en;

    logic                  out_valid_reg;
    logic [REQ_W-1:0]      out_req_reg;
    logic [NUM_TIMERS-1:0] out_wrap_reg;
    logic [DATA_W-1:0]     out_t0_reg;
    logic [DATA_W-1:0]     out_t1_reg;
    logic [NUM_TIMERS-1:0] out_ovf_reg;
    logic [DATA_W-1:0]     out_chan_reg;

    cctu_timer_ctl_t       tmr_ctl   [NUM_TIMERS];
    cctu_timer_sts_t       tmr_sts   [NUM_TIMERS];
    logic [TIMER_BITS-1:0] count_cur [NUM_TIMERS];
    logic [REQ_W-1:0]      chan_requests;
    logic [DATA_W-1:0]     chan_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_control_reg <= '0;
            reload_zero_reg   <= '0;
            reload_one_reg    <= '0;
            channel_modes_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cctu_cfg_idx_t'(cfg_index))
                CFG_TIMER_CONTROL: timer_control_reg <= cfg_data[3:0];
                CFG_RELOAD_ZERO:   reload_zero_reg   <= cfg_data[DATA_W-1:0];
                CFG_RELOAD_ONE:    reload_one_reg    <= cfg_data[DATA_W-1:0];
                CFG_CHANNEL_MODES: channel_modes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The held item moves on whenever the result register is empty or being drained.
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.func   <= cctu_func_t'(s_func);
            in_item_reg.idx    <= s_index;
            in_item_reg.level  <= s_level;
            in_item_reg.data   <= s_data;
            in_item_reg.ovf_in <= s_overflow_in;
        end
    end

    always_comb begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
            // A timer counts on ticks only when running and not in external mode.
            tmr_ctl[t].tick    = (in_item_reg.func == FUNC_TICK) &&
                                 timer_control_reg[2*t] && !timer_control_reg[2*t+1];
            tmr_ctl[t].wr      = (in_item_reg.func == FUNC_WR_TIMER) &&
                                 (int'(in_item_reg.idx[0]) == t);
            tmr_ctl[t].wr_data = TIMER_BITS'(in_item_reg.data);
            tmr_ctl[t].wr_ovf  = in_item_reg.ovf_in;
        end
        tmr_ctl[0].reload = TIMER_BITS'(reload_zero_reg);
        tmr_ctl[1].reload = TIMER_BITS'(reload_one_reg);
    end

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
        cctu_timer u_timer (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step_en   (step_en),
            .ctl       (tmr_ctl[g]),
            .count_cur (count_cur[g]),
            .sts       (tmr_sts[g])
        );
    end

    cctu_channels u_channels (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .item      (in_item_reg),
        .modes     (channel_modes_reg),
        .count_cur (count_cur),
        .tmr_sts   (tmr_sts),
        .requests  (chan_requests),
        .value_out (chan_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_req_reg  <= chan_requests;
            out_wrap_reg <= {tmr_sts[1].wrapped, tmr_sts[0].wrapped};
            out_t0_reg   <= DATA_W'(tmr_sts[0].count_next);
            out_t1_reg   <= DATA_W'(tmr_sts[1].count_next);
            out_ovf_reg  <= {tmr_sts[1].ovf_next, tmr_sts[0].ovf_next};
            out_chan_reg <= chan_value;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_channel_requests = out_req_reg;
    assign m_wrap_requests    = out_wrap_reg;
    assign m_timer_zero_value = out_t0_reg;
    assign m_timer_one_value  = out_t1_reg;
    assign m_overflow_flags   = out_ovf_reg;
    assign m_channel_value    = out_chan_reg;

endmodule

`default_nettype wire

>>> design/cctu_checker.sv
// Port-level checker for the capture/compare timer unit, bound to the top level.
`default_nettype none

module cctu_checker
    import cctu_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [REQ_W-1:0]      m_channel_requests,
    input wire logic [NUM_TIMERS-1:0] m_wrap_requests,
    input wire logic [DATA_W-1:0]     m_timer_zero_value,
    input wire logic [DATA_W-1:0]     m_timer_one_value,
    input wire logic [NUM_TIMERS-1:0] m_overflow_flags,
    input wire logic [DATA_W-1:0]     m_channel_value,
    input wire logic                  cfg_ready
);

    // No result is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_channel_requests) &&
        $stable(m_wrap_requests) && $stable(m_timer_zero_value) &&
        $stable(m_timer_one_value) && $stable(m_overflow_flags) &&
        $stable(m_channel_value))
        else $error("stalled result changed");

    // A timer that wrapped during the transaction has its sticky overflow flag set.
    a_wrap_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_wrap_requests & ~m_overflow_flags) == '0)
        else $error("wrap reported without overflow flag");

    // The configuration channel never stalls.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind capture_compare_timer_unit_core cctu_checker u_cctu_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_channel_requests (m_channel_requests),
    .m_wrap_requests    (m_wrap_requests),
    .m_timer_zero_value (m_timer_zero_value),
    .m_timer_one_value  (m_timer_one_value),
    .m_overflow_flags   (m_overflow_flags),
    .m_channel_value    (m_channel_value),
    .cfg_ready          (cfg_ready)
);

`default_nettype wire
